@@ src/gql_pkg.sv @@
// Shared types and constants of the glyph quad layout core.
package gql_pkg;

  localparam int GLYPH_COUNT = 256;
  localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);

  // Glyphs whose metrics set the scale at text start.
  localparam int SCALE_H_CODE  = 65;
  localparam int SCALE_OY_CODE = 103;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_CHAR  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_VERTEX  = 2'd0,
    ST_CLIPPED = 2'd1,
    ST_MISSING = 2'd2,
    ST_NO_TEXT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_BOX_X       = 2'd0,
    REG_BOX_Y       = 2'd1,
    REG_BOX_WIDTH   = 2'd2,
    REG_TEXT_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_RD_H  = 11'b000_0000_0010,
    S_RD_OY = 11'b000_0000_0100,
    S_DENOM = 11'b000_0000_1000,
    S_DIV   = 11'b000_0001_0000,
    S_RDC   = 11'b000_0010_0000,
    S_LATCH = 11'b000_0100_0000,
    S_MUL   = 11'b000_1000_0000,
    S_NDC   = 11'b001_0000_0000,
    S_EMIT  = 11'b010_0000_0000,
    S_STAT  = 11'b100_0000_0000
  } state_t;

  localparam logic [11:0] BOX_X_RST       = 12'd0;
  localparam logic [11:0] BOX_Y_RST       = 12'd0;
  localparam logic [11:0] BOX_WIDTH_RST   = 12'd800;
  localparam logic [11:0] TEXT_HEIGHT_RST = 12'd32;

  // Pixel to NDC: x = floor((p + 400) / 800), y = floor((p + 300) / 600), p in Q.16.
  localparam logic signed [40:0] NDC_X_BIAS  = 41'sd400;
  localparam logic signed [40:0] NDC_Y_BIAS  = 41'sd300;
  localparam logic signed [40:0] NDC_X_LIMIT = 41'sd52428800;
  localparam logic signed [40:0] NDC_Y_LIMIT = 41'sd39321600;
  // After the power-of-two shift, divide by 25 (x) or 75 (y) by reciprocal.
  localparam logic [22:0] NDC_X_RECIP = 23'd2684354;
  localparam logic [22:0] NDC_Y_RECIP = 23'd7158278;
  localparam logic [6:0]  NDC_X_DIV   = 7'd25;
  localparam logic [6:0]  NDC_Y_DIV   = 7'd75;

  localparam logic [23:0] SCALE_MAX = 24'hFF_FFFF;

endpackage

@@ src/glyph_quad_layout_core.sv @@
// Top level of the glyph quad layout core: glyph table, scale divider and vertex sequencer.
//
// Usage. Requests arrive on the in_ channel (in_valid / in_stall). A load request
// writes one glyph's metrics into the on-chip glyph table and gives no result. A start
// request derives the scale from glyphs 65 and 103 and opens a text at box_x. A
// character request gives six vertex results (corners 0 to 5, last on corner 5) or a
// single status result. Results leave on the out_ channel through an output register.
// Registers box_x, box_y, box_width and text_height sit on the APB port at byte
// addresses 0, 4, 8 and 12; write them only while the core is idle.
// Sequencing. One request is worked on at a time. A start whose glyph 65 or 103 is not
// loaded gives a status result; otherwise, when the denominator is positive, it runs the
// scale division (one quotient bit per cycle over 28 bits). A placed character passes
// through the accepting cycle, one glyph table read, a latch of the fields, the shared
// scale multiplier, pixel to NDC conversion and vertex output. A clipped character ends
// after the scale multiplier with a status result; any other status result is sent from
// the status state straight after acceptance.
// Reset clears the glyph valid bits, cursor, scale and open text flag, and resets the
// registers; the glyph table itself is not cleared and needs no clearing pass.
// When the receiver stalls, the pending result holds in the output register and the
// sequencer waits, so in_stall stays high until the last result has entered that register.
module glyph_quad_layout_core
  import gql_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_char_code,
  input  logic [11:0]        in_atlas_x,
  input  logic [11:0]        in_atlas_y,
  input  logic [11:0]        in_glyph_width,
  input  logic [11:0]        in_glyph_height,
  input  logic signed [11:0] in_offset_x,
  input  logic signed [11:0] in_offset_y,
  input  logic [11:0]        in_advance,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic [15:0]        out_tex_u,
  output logic [15:0]        out_tex_v,
  output logic [2:0]         out_corner,
  output logic               out_last,
  output logic [1:0]         out_status,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers
  logic [11:0] box_x_r, box_y_r, box_w_r, text_h_r;

  // Control state
  state_t      state_r, state_nxt;
  logic        text_open_r;
  logic [23:0] cursor_r;
  logic [23:0] scale_r;
  logic [GLYPH_COUNT-1:0] valid_r;
  logic [1:0]  stat_code_r;
  logic [7:0]  code_r;

  // Glyph table: {advance, offset_y, offset_x, height, width, atlas_y, atlas_x}
  logic [83:0] glyph_mem [GLYPH_COUNT];
  logic [83:0] rdata_r;
  logic [GLYPH_AW-1:0] rd_addr;
  logic        rd_en;

  // Scale divider
  logic [11:0] h65_r;
  logic [12:0] denom_r;
  logic [12:0] rem_r;
  logic [27:0] dvd_r;
  logic [4:0]  div_cnt_r;
  logic [13:0] div_trial;
  logic        div_ge;
  logic signed [13:0] denom_calc;

  // Latched glyph fields
  logic [11:0] ax_r, ay_r, gw_r, gh_r, adv_r;
  logic signed [11:0] ox_r, oy_r;

  // Shared scale multiplier
  logic [2:0]  mul_cnt_r;
  logic signed [12:0] mul_b;
  logic signed [37:0] mul_p;
  logic signed [37:0] prod_r;
  logic [28:0] nc_sum;
  logic [23:0] nc_r;
  logic [20:0] clip_bound;
  logic signed [39:0] pxl_r, pxr_r, pyo_r, pyt_r;

  // Pixel to NDC converter
  logic [2:0]  ndc_cnt_r;
  logic        ndc_is_x;
  logic signed [39:0] ndc_val;
  logic signed [40:0] ndc_t;
  logic [22:0] ndc_xs;
  logic [22:0] xs_r;
  logic        neg_r, over_r;
  logic [45:0] prod2_r;
  logic [16:0] q0;
  logic [23:0] q0_mul;
  logic [23:0] rem_c;
  logic [16:0] q_fin;
  logic [16:0] y_diff;
  logic signed [15:0] ndc_res;
  logic signed [15:0] xl_r, xr_r, yo_r, yt_r;

  // Vertex output
  logic [2:0]  corner_r;
  logic        is_right, is_top;
  logic [12:0] u_sum, v_sum;
  logic        out_free, out_load;
  logic        out_valid_r;
  logic signed [15:0] pos_x_r, pos_y_r;
  logic [15:0] tex_u_r, tex_v_r;
  logic [2:0]  corner_out_r;
  logic        last_r;
  logic [1:0]  status_r;

  logic        in_acc;
  logic        cfg_wr;
  logic        code_ok;

  // Texture coordinate: atlas pixels times 64, saturated.
  function automatic logic [15:0] tex_sat(input logic [12:0] pix);
    tex_sat = (pix[12:10] != 3'd0) ? 16'hFFFF : {pix[9:0], 6'd0};
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign code_ok  = ({1'b0, in_char_code} < 9'(GLYPH_COUNT));

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_BOX_X:       prdata = {20'd0, box_x_r};
      REG_BOX_Y:       prdata = {20'd0, box_y_r};
      REG_BOX_WIDTH:   prdata = {20'd0, box_w_r};
      REG_TEXT_HEIGHT: prdata = {20'd0, text_h_r};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r  <= BOX_X_RST;
      box_y_r  <= BOX_Y_RST;
      box_w_r  <= BOX_WIDTH_RST;
      text_h_r <= TEXT_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_BOX_X:       box_x_r  <= pwdata[11:0];
        REG_BOX_Y:       box_y_r  <= pwdata[11:0];
        REG_BOX_WIDTH:   box_w_r  <= pwdata[11:0];
        REG_TEXT_HEIGHT: text_h_r <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // The table is written only on an accepted load and read only in later states,
  // so a read never meets a write to the same entry in flight.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = code_r[GLYPH_AW-1:0];
    case (state_r)
      S_RD_H: begin
        rd_en   = 1'b1;
        rd_addr = GLYPH_AW'(SCALE_H_CODE);
      end
      S_RD_OY: begin
        rd_en   = 1'b1;
        rd_addr = GLYPH_AW'(SCALE_OY_CODE);
      end
      S_RDC: begin
        rd_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && (cmd_t'(in_command) == CMD_LOAD) && code_ok) begin
      glyph_mem[in_char_code[GLYPH_AW-1:0]] <= {in_advance, in_offset_y, in_offset_x,
        in_glyph_height, in_glyph_width, in_atlas_y, in_atlas_x};
    end
    if (rd_en) begin
      rdata_r <= glyph_mem[rd_addr];
    end
  end

  // Scale denominator: height of the capital plus twice the descender offset.
  assign denom_calc = $signed({2'b00, h65_r}) + 14'($signed(rdata_r[71:60]) * 2);
  assign div_trial  = {rem_r, dvd_r[27]};
  assign div_ge     = (div_trial >= {1'b0, denom_r});

  // One multiplier serves all five scaled metrics in turn.
  always_comb begin
    case (mul_cnt_r)
      3'd0:    mul_b = $signed({1'b0, adv_r});
      3'd1:    mul_b = 13'(ox_r);
      3'd2:    mul_b = $signed({1'b0, gw_r});
      3'd3:    mul_b = 13'(oy_r);
      default: mul_b = $signed({1'b0, gh_r});
    endcase
  end
  assign mul_p      = $signed({1'b0, scale_r}) * mul_b;
  assign nc_sum     = {5'd0, cursor_r} + {1'b0, prod_r[35:8]};
  assign clip_bound = {({1'b0, box_x_r} + {1'b0, box_w_r}), 8'd0};

  // NDC conversion of each coordinate: reciprocal product, then correction.
  assign ndc_is_x = !ndc_cnt_r[2];
  always_comb begin
    case (ndc_cnt_r[2:1])
      2'd0:    ndc_val = pxl_r;
      2'd1:    ndc_val = pxr_r;
      2'd2:    ndc_val = pyo_r;
      default: ndc_val = pyt_r;
    endcase
  end
  assign ndc_t  = 41'(ndc_val) + (ndc_is_x ? NDC_X_BIAS : NDC_Y_BIAS);
  assign ndc_xs = ndc_is_x ? {2'd0, ndc_t[25:5]} : ndc_t[25:3];

  assign q0     = ndc_is_x ? prod2_r[42:26] : prod2_r[45:29];
  assign q0_mul = 24'(q0) * 24'(ndc_is_x ? NDC_X_DIV : NDC_Y_DIV);
  assign rem_c  = {1'b0, xs_r} - q0_mul;
  assign q_fin  = q0 + 17'(rem_c >= 24'(ndc_is_x ? NDC_X_DIV : NDC_Y_DIV));
  assign y_diff = 17'd32768 - q_fin;

  always_comb begin
    if (ndc_is_x) begin
      if (neg_r) begin
        ndc_res = 16'sh8000;
      end else if (over_r) begin
        ndc_res = 16'sd32767;
      end else begin
        ndc_res = $signed({~q_fin[15], q_fin[14:0]});
      end
    end else begin
      if (neg_r || (!over_r && q_fin == 17'd0)) begin
        ndc_res = 16'sd32767;
      end else if (over_r) begin
        ndc_res = 16'sh8000;
      end else begin
        ndc_res = $signed(y_diff[15:0]);
      end
    end
  end

  // Corner order: 0 left/top, 1 left/offset, 2 right/offset, 3 left/top,
  // 4 right/top, 5 right/offset.
  assign is_right = (corner_r == 3'd2) || (corner_r == 3'd4) || (corner_r == 3'd5);
  assign is_top   = (corner_r == 3'd0) || (corner_r == 3'd3) || (corner_r == 3'd4);
  assign u_sum    = {1'b0, ax_r} + (is_right ? {1'b0, gw_r} : 13'd0);
  assign v_sum    = {1'b0, ay_r} + (is_top ? {1'b0, gh_r} : 13'd0);

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free && ((state_r == S_EMIT) || (state_r == S_STAT));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd_t'(in_command))
            CMD_START: begin
              if (valid_r[SCALE_H_CODE] && valid_r[SCALE_OY_CODE]) begin
                state_nxt = S_RD_H;
              end else begin
                state_nxt = S_STAT;
              end
            end
            CMD_CHAR: begin
              if (text_open_r && code_ok && valid_r[in_char_code[GLYPH_AW-1:0]]) begin
                state_nxt = S_RDC;
              end else begin
                state_nxt = S_STAT;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_H:  state_nxt = S_RD_OY;
      S_RD_OY: state_nxt = S_DENOM;
      S_DENOM: begin
        state_nxt = (denom_calc > 14'sd0) ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (div_cnt_r == 5'd27) begin
          state_nxt = S_IDLE;
        end
      end
      S_RDC:   state_nxt = S_LATCH;
      S_LATCH: state_nxt = S_MUL;
      S_MUL: begin
        if (mul_cnt_r == 3'd5) begin
          state_nxt = (nc_r >= 24'(clip_bound)) ? S_STAT : S_NDC;
        end
      end
      S_NDC: begin
        if (ndc_cnt_r == 3'd7) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free && corner_r == 3'd5) begin
          state_nxt = S_IDLE;
        end
      end
      S_STAT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      text_open_r <= 1'b0;
      cursor_r    <= 24'd0;
      scale_r     <= 24'd0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (in_acc) begin
        code_r <= in_char_code;
        case (cmd_t'(in_command))
          CMD_LOAD: begin
            if (code_ok) begin
              valid_r[in_char_code[GLYPH_AW-1:0]] <= 1'b1;
            end
          end
          CMD_START: begin
            if (!(valid_r[SCALE_H_CODE] && valid_r[SCALE_OY_CODE])) begin
              text_open_r <= 1'b0;
              stat_code_r <= ST_MISSING;
            end
          end
          CMD_CHAR: begin
            stat_code_r <= text_open_r ? ST_MISSING : ST_NO_TEXT;
          end
          default: ;
        endcase
      end

      case (state_r)
        S_RD_OY: h65_r <= rdata_r[47:36];
        S_DENOM: begin
          denom_r   <= denom_calc[12:0];
          rem_r     <= 13'd0;
          dvd_r     <= {text_h_r, 16'd0};
          div_cnt_r <= 5'd0;
          if (denom_calc <= 14'sd0) begin
            scale_r     <= SCALE_MAX;
            cursor_r    <= {box_x_r, 8'd0};
            text_open_r <= 1'b1;
          end
        end
        S_DIV: begin
          rem_r     <= div_ge ? 13'(div_trial - {1'b0, denom_r}) : div_trial[12:0];
          dvd_r     <= {dvd_r[26:0], div_ge};
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == 5'd27) begin
            scale_r     <= (dvd_r[26:23] != 4'd0) ? SCALE_MAX : {dvd_r[22:0], div_ge};
            cursor_r    <= {box_x_r, 8'd0};
            text_open_r <= 1'b1;
          end
        end
        S_LATCH: begin
          ax_r      <= rdata_r[11:0];
          ay_r      <= rdata_r[23:12];
          gw_r      <= rdata_r[35:24];
          gh_r      <= rdata_r[47:36];
          ox_r      <= $signed(rdata_r[59:48]);
          oy_r      <= $signed(rdata_r[71:60]);
          adv_r     <= rdata_r[83:72];
          mul_cnt_r <= 3'd0;
        end
        S_MUL: begin
          // Each step registers one product; every step after the first folds in the previous one.
          prod_r    <= mul_p;
          mul_cnt_r <= mul_cnt_r + 3'd1;
          case (mul_cnt_r)
            3'd1: nc_r  <= (nc_sum[28:24] != 5'd0) ? SCALE_MAX : nc_sum[23:0];
            3'd2: pxl_r <= $signed({8'd0, cursor_r, 8'd0}) + 40'(prod_r);
            3'd3: pxr_r <= pxl_r + 40'(prod_r);
            3'd4: pyo_r <= $signed({12'd0, box_y_r, 16'd0}) + 40'(prod_r);
            3'd5: begin
              pyt_r    <= pyo_r + 40'(prod_r);
              cursor_r <= nc_r;
              if (nc_r >= 24'(clip_bound)) begin
                text_open_r <= 1'b0;
                stat_code_r <= ST_CLIPPED;
              end
            end
            default: ;
          endcase
          ndc_cnt_r <= 3'd0;
        end
        S_NDC: begin
          ndc_cnt_r <= ndc_cnt_r + 3'd1;
          if (!ndc_cnt_r[0]) begin
            neg_r   <= ndc_t[40];
            over_r  <= !ndc_t[40] && (ndc_t >= (ndc_is_x ? NDC_X_LIMIT : NDC_Y_LIMIT));
            xs_r    <= ndc_xs;
            prod2_r <= 46'(ndc_xs) * 46'(ndc_is_x ? NDC_X_RECIP : NDC_Y_RECIP);
          end else begin
            case (ndc_cnt_r[2:1])
              2'd0:    xl_r <= ndc_res;
              2'd1:    xr_r <= ndc_res;
              2'd2:    yo_r <= ndc_res;
              default: yt_r <= ndc_res;
            endcase
          end
          corner_r <= 3'd0;
        end
        S_EMIT: begin
          if (out_free) begin
            corner_r <= corner_r + 3'd1;
          end
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == S_EMIT) begin
        pos_x_r      <= is_right ? xr_r : xl_r;
        pos_y_r      <= is_top ? yt_r : yo_r;
        tex_u_r      <= tex_sat(u_sum);
        tex_v_r      <= tex_sat(v_sum);
        corner_out_r <= corner_r;
        last_r       <= (corner_r == 3'd5);
        status_r     <= ST_VERTEX;
      end else begin
        pos_x_r      <= 16'sd0;
        pos_y_r      <= 16'sd0;
        tex_u_r      <= 16'd0;
        tex_v_r      <= 16'd0;
        corner_out_r <= 3'd0;
        last_r       <= 1'b1;
        status_r     <= stat_code_r;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_pos_x  = pos_x_r;
  assign out_pos_y  = pos_y_r;
  assign out_tex_u  = tex_u_r;
  assign out_tex_v  = tex_v_r;
  assign out_corner = corner_out_r;
  assign out_last   = last_r;
  assign out_status = status_r;

  // The sequencer is always in exactly one state.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  // Vertices are only produced for an open text.
  a_emit_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> text_open_r)
    else $error("vertex output without an open text");

  // Every status result is the only and therefore last result of its request.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_VERTEX) |-> last_r)
    else $error("status result without last");

  // The divider never runs on a zero denominator.
  a_div_denom: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (denom_r != 13'd0))
    else $error("scale division with zero denominator");

endmodule
